// ----- hw/rtl/bdq_pkg.sv -----
// Shared codes, widths and defaults for the bounded deque with search.
`timescale 1ns / 1ps

package bdq_pkg;

	localparam int DATA_W      = 32;
	localparam int MODE_W      = 3;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 5;
	localparam int DEPTH_DEF   = 16;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DELETE     = 3'd4;
	localparam logic [MODE_W-1:0] MODE_FIND       = 3'd5;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// value reported when nothing was popped
	localparam logic [DATA_W-1:0] NONE_VALUE = '1;

endpackage

// ----- hw/rtl/bdq_mem.sv -----
// Entry store: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module bdq_mem import bdq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// write entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read entry; read data is registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/bounded_deque_with_search.sv -----
// Top level of the bounded deque with search: control, pointers and results.
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit entries with delete-by-value
// and find. Entries live in a circular buffer in one synchronous memory; a
// head pointer and a count give the front and the back.
// Input: an item (mode, operand_value) is taken at a clock edge where start
// is high and busy is low. Output: each item gives exactly one result,
// shown for one cycle with done high: popped_value, found, status and
// entry_count (count after the item, low 5 bits). The receiver cannot stall.
// How each item runs, start edge to done cycle:
//   push front / push back, full pushes, empty pops, unused modes, and find
//     or delete on an empty store: no memory read, and a new item may follow at once.
//   pop front / pop back: one memory read, then the read data is handed out.
//   find: the scan reads one entry per cycle from the memory port, from the front
//     (position 0) on, and stops at the first match or after the back entry.
//   delete: as find to locate the entry, then each entry behind it is read and
//     written one place toward the front to close the gap.
// busy is high while a pop, find or delete is at work.
// Reset (arst_n low) empties the store at once; entry contents stay
// unknown and are never read before they are written.
module bounded_deque_with_search import bdq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [MODE_W-1:0]        mode,
	input  logic signed [DATA_W-1:0] operand_value,
	output logic                     done,
	output logic signed [DATA_W-1:0] popped_value,
	output logic                     found,
	output logic [STATUS_W-1:0]      status,
	output logic [COUNT_OUT_W-1:0]   entry_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

	// controller states
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_POP   = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_SHIFT = 2'd3;

	logic [1:0]        st_q;
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     cnt_q;
	logic [MODE_W-1:0] op_q;
	logic [DATA_W-1:0] val_q;
	logic [CW-1:0]     idx_q;
	logic              pend_s1;
	logic [CW-1:0]     pend_idx_s1;

	logic                done_q;
	logic [DATA_W-1:0]   popped_q;
	logic                found_q;
	logic [STATUS_W-1:0] status_q;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;

	logic              accept;
	logic              is_full;
	logic              is_empty;
	logic [AW-1:0]     head_dec;
	logic [AW-1:0]     head_inc;
	logic [CW-1:0]     cnt_dec;
	logic              hit;
	logic              last_back;
	logic [CW+COUNT_OUT_W-1:0] cnt_ext;

	// map a logical position (below DEPTH) onto a memory address
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
		input logic [CW-1:0] pos);
		logic [AW+CW:0] sum;
		sum = (AW + CW + 1)'(base) + (AW + CW + 1)'(pos);
		if (sum >= (AW + CW + 1)'(DEPTH)) begin
			sum = sum - (AW + CW + 1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign accept    = start && !busy;
	assign busy      = (st_q != S_IDLE);
	assign is_full   = (cnt_q >= DEPTH_C);
	assign is_empty  = (cnt_q == '0);
	assign cnt_dec   = cnt_q - CW'(1);
	assign head_dec  = (head_q == '0) ? LAST_PTR : head_q - AW'(1);
	assign head_inc  = (head_q == LAST_PTR) ? '0 : head_q + AW'(1);
	assign hit       = pend_s1 && (mem_rdata == val_q);
	assign last_back = pend_s1 && (pend_idx_s1 == cnt_dec);

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = val_q;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (st_q)
			S_IDLE: begin
				if (accept && mode == MODE_PUSH_FRONT && !is_full) begin
					mem_we    = 1'b1;
					mem_waddr = head_dec;
					mem_wdata = operand_value;
				end else if (accept && mode == MODE_PUSH_BACK && !is_full) begin
					mem_we    = 1'b1;
					mem_waddr = phys(head_q, cnt_q);
					mem_wdata = operand_value;
				end else if (accept && mode == MODE_POP_FRONT && !is_empty) begin
					mem_re    = 1'b1;
					mem_raddr = head_q;
				end else if (accept && mode == MODE_POP_BACK && !is_empty) begin
					mem_re    = 1'b1;
					mem_raddr = phys(head_q, cnt_dec);
				end
			end
			S_SCAN: begin
				if (!hit && !last_back && idx_q < cnt_q) begin
					mem_re    = 1'b1;
					mem_raddr = phys(head_q, idx_q);
				end
			end
			S_SHIFT: begin
				// move the returned entry one place toward the front
				if (pend_s1) begin
					mem_we    = 1'b1;
					mem_waddr = phys(head_q, pend_idx_s1 - CW'(1));
					mem_wdata = mem_rdata;
				end
				if (!last_back && idx_q < cnt_q) begin
					mem_re    = 1'b1;
					mem_raddr = phys(head_q, idx_q);
				end
			end
			default: begin
			end
		endcase
	end

	bdq_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// sequence items, advance pointers and post results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			head_q  <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			pend_s1 <= mem_re;
			if (mem_re) begin
				pend_idx_s1 <= idx_q;
			end
			case (st_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= mode;
						val_q    <= operand_value;
						popped_q <= NONE_VALUE;
						found_q  <= 1'b0;
						status_q <= ST_OK;
						idx_q    <= '0;
						case (mode)
							MODE_PUSH_FRONT: begin
								done_q <= 1'b1;
								if (is_full) begin
									status_q <= ST_FULL;
								end else begin
									head_q <= head_dec;
									cnt_q  <= cnt_q + CW'(1);
								end
							end
							MODE_PUSH_BACK: begin
								done_q <= 1'b1;
								if (is_full) begin
									status_q <= ST_FULL;
								end else begin
									cnt_q <= cnt_q + CW'(1);
								end
							end
							MODE_POP_FRONT, MODE_POP_BACK: begin
								if (is_empty) begin
									done_q   <= 1'b1;
									status_q <= ST_EMPTY;
								end else begin
									st_q <= S_POP;
								end
							end
							MODE_DELETE, MODE_FIND: begin
								if (is_empty) begin
									done_q <= 1'b1;
								end else begin
									st_q <= S_SCAN;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_POP: begin
					// read data is back: hand it out and drop the entry
					popped_q <= mem_rdata;
					done_q   <= 1'b1;
					cnt_q    <= cnt_dec;
					if (op_q == MODE_POP_FRONT) begin
						head_q <= head_inc;
					end
					st_q <= S_IDLE;
				end
				S_SCAN: begin
					if (hit) begin
						found_q <= 1'b1;
						if (op_q == MODE_FIND) begin
							done_q <= 1'b1;
							st_q   <= S_IDLE;
						end else if (last_back) begin
							cnt_q  <= cnt_dec;
							done_q <= 1'b1;
							st_q   <= S_IDLE;
						end else begin
							idx_q <= pend_idx_s1 + CW'(1);
							st_q  <= S_SHIFT;
						end
					end else if (last_back) begin
						done_q <= 1'b1;
						st_q   <= S_IDLE;
					end else if (mem_re) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_SHIFT: begin
					if (last_back) begin
						cnt_q  <= cnt_dec;
						done_q <= 1'b1;
						st_q   <= S_IDLE;
					end else if (mem_re) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cnt_ext      = {{COUNT_OUT_W{1'b0}}, cnt_q};
	assign done         = done_q;
	assign popped_value = popped_q;
	assign found        = found_q;
	assign status       = status_q;
	assign entry_count  = cnt_ext[COUNT_OUT_W-1:0];

	// count never passes the bound
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= DEPTH_C)
		else $error("entry count above depth");

	// a push always answers on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (mode == MODE_PUSH_FRONT || mode == MODE_PUSH_BACK)) |=> done)
		else $error("push result missing");

	// a scan read in flight always targets a stored entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s1 && (st_q == S_SCAN || st_q == S_SHIFT)) |-> (pend_idx_s1 < cnt_q))
		else $error("scan read beyond the stored entries");

	// an empty-pop status comes only from an empty store
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (cnt_q == '0))
		else $error("empty status with entries present");

endmodule

// ----- tb/bounded_deque_with_search_test.sv -----
// Testbench for the bounded deque with search: directed and random command traffic against a shadow deque.
`timescale 1ns / 1ps

module bounded_deque_with_search_test;
	import bdq_pkg::*;

	localparam int SLOTS       = DEPTH_DEF;
	localparam int RAND_ITEMS  = 1950;
	localparam int DRAIN_AT    = 1000;
	localparam int CALM_LO     = 700;
	localparam int CALM_HI     = 1000;
	localparam int IDLE_PCT    = 14;
	localparam int TAIL_CYCLES = 40;
	localparam int LIMIT_CYCLES = 400000;

	// modes the block treats as no operation
	localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

	typedef struct {
		logic [MODE_W-1:0]        op;
		logic signed [DATA_W-1:0] val;
		bit                       drain_first;
	} deque_cmd_t;

	typedef struct {
		logic signed [DATA_W-1:0] popped;
		logic                     hit;
		logic [STATUS_W-1:0]      st;
		logic [COUNT_OUT_W-1:0]   count;
	} deque_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [MODE_W-1:0] mode = MODE_SPARE6;
	logic signed [DATA_W-1:0] operand_value = '0;
	logic busy;
	logic done;
	logic signed [DATA_W-1:0] popped_value;
	logic found;
	logic [STATUS_W-1:0] status;
	logic [COUNT_OUT_W-1:0] entry_count;

	deque_cmd_t pending_cmds[$];
	deque_result_t awaited_results[$];
	logic signed [DATA_W-1:0] shadow_vals[$];
	logic signed [DATA_W-1:0] value_pool[8];

	bit took = 1'b0;
	int n_accepted = 0;
	int fail_count = 0;
	int cycles = 0;
	int mode_hits[8];
	int full_hits = 0;
	int empty_hits = 0;
	int match_hits = 0;

	bounded_deque_with_search u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.operand_value(operand_value),
		.done         (done),
		.popped_value (popped_value),
		.found        (found),
		.status       (status),
		.entry_count  (entry_count)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Apply one item to the shadow deque and return the result it should give.
	function automatic deque_result_t step_deque_shadow(input logic [MODE_W-1:0] op,
			input logic signed [DATA_W-1:0] val);
		deque_result_t r;
		int first_hit;
		r.popped = NONE_VALUE;
		r.hit = 1'b0;
		r.st = ST_OK;
		first_hit = -1;
		case (op)
			MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
				if (shadow_vals.size() >= SLOTS)
					r.st = ST_FULL;
				else if (op == MODE_PUSH_FRONT)
					shadow_vals.push_front(val);
				else
					shadow_vals.push_back(val);
			end
			MODE_POP_FRONT, MODE_POP_BACK: begin
				if (shadow_vals.size() == 0)
					r.st = ST_EMPTY;
				else if (op == MODE_POP_FRONT)
					r.popped = shadow_vals.pop_front();
				else
					r.popped = shadow_vals.pop_back();
			end
			MODE_DELETE, MODE_FIND: begin
				// search from the front; the first match wins
				for (int i = 0; i < shadow_vals.size(); i++)
					if (first_hit < 0 && shadow_vals[i] == val)
						first_hit = i;
				if (first_hit >= 0) begin
					r.hit = 1'b1;
					if (op == MODE_DELETE)
						shadow_vals.delete(first_hit);
				end
			end
			default: ;
		endcase
		r.count = COUNT_OUT_W'(shadow_vals.size());
		return r;
	endfunction

	task automatic queue_cmd(input logic [MODE_W-1:0] op, input logic signed [DATA_W-1:0] val,
			input bit drain_first);
		deque_cmd_t c;
		c.op = op;
		c.val = val;
		c.drain_first = drain_first;
		pending_cmds.push_back(c);
	endtask

	// Build the random part in bursts that lean toward filling, draining or a mix.
	task automatic queue_random_cmds();
		int made;
		int lean;
		int burst;
		int roll;
		logic [MODE_W-1:0] op;
		logic signed [DATA_W-1:0] val;
		made = 0;
		while (made < RAND_ITEMS) begin
			lean = $urandom_range(0, 2);
			burst = $urandom_range(10, 40);
			for (int j = 0; j < burst && made < RAND_ITEMS; j++) begin
				roll = $urandom_range(0, 99);
				if (roll < (lean == 0 ? 55 : lean == 1 ? 20 : 35))
					op = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
				else if (roll < (lean == 0 ? 70 : lean == 1 ? 65 : 55))
					op = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
				else if (roll < (lean == 0 ? 85 : lean == 1 ? 80 : 75))
					op = MODE_DELETE;
				else if (roll < 97)
					op = MODE_FIND;
				else
					op = $urandom_range(0, 1) ? MODE_SPARE6 : MODE_SPARE7;
				// pool values make matches and duplicates common
				if ($urandom_range(0, 99) < 70)
					val = value_pool[$urandom_range(0, 7)];
				else
					val = $urandom;
				queue_cmd(op, val, made == 0 || made == DRAIN_AT);
				made++;
			end
		end
	endtask

	// Drive the next item at the falling edge; hold an offered item until taken.
	always @(negedge clk) begin
		if (!arst_n)
			start <= 1'b0;
		else if (start && !took) begin
		end else if (pending_cmds.size() == 0
				|| (pending_cmds[0].drain_first && awaited_results.size() != 0)
				|| (!(n_accepted >= CALM_LO && n_accepted < CALM_HI)
					&& $urandom_range(0, 99) < IDLE_PCT))
			start <= 1'b0;
		else begin
			start <= 1'b1;
			mode <= pending_cmds[0].op;
			operand_value <= pending_cmds[0].val;
		end
	end

	// Check results and record accepted items at the rising edge.
	always @(posedge clk) begin
		deque_result_t want;
		deque_result_t got;
		if (arst_n) begin
			// the result belongs to an earlier item, so check before recording
			if (done) begin
				if (awaited_results.size() == 0) begin
					$error("result with no item outstanding");
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (popped_value !== want.popped) begin
						$error("popped_value: expected %0d, got %0d", want.popped, popped_value);
						fail_count++;
					end
					if (found !== want.hit) begin
						$error("found: expected %0d, got %0d", want.hit, found);
						fail_count++;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						fail_count++;
					end
					if (entry_count !== want.count) begin
						$error("entry_count: expected %0d, got %0d", want.count, entry_count);
						fail_count++;
					end
				end
			end
			took <= start && !busy;
			if (start && !busy) begin
				got = step_deque_shadow(mode, operand_value);
				awaited_results.push_back(got);
				void'(pending_cmds.pop_front());
				n_accepted++;
				mode_hits[mode]++;
				if (got.st == ST_FULL)
					full_hits++;
				if (got.st == ST_EMPTY)
					empty_hits++;
				if (got.hit)
					match_hits++;
			end
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		value_pool[0] = -1;
		value_pool[1] = 0;
		value_pool[2] = VAL_MAX;
		value_pool[3] = VAL_MIN;
		for (int i = 4; i < 8; i++)
			value_pool[i] = $urandom;

		// empty store: pops, delete, find and the spare modes
		queue_cmd(MODE_POP_FRONT, 5, 1'b0);
		queue_cmd(MODE_POP_BACK, -1, 1'b0);
		queue_cmd(MODE_DELETE, 0, 1'b0);
		queue_cmd(MODE_FIND, 0, 1'b0);
		queue_cmd(MODE_SPARE6, VAL_MAX, 1'b0);
		queue_cmd(MODE_SPARE7, VAL_MIN, 1'b0);
		// extremes, a stored -1 and a duplicate
		queue_cmd(MODE_PUSH_BACK, VAL_MAX, 1'b0);
		queue_cmd(MODE_PUSH_FRONT, VAL_MIN, 1'b0);
		queue_cmd(MODE_PUSH_BACK, -1, 1'b0);
		queue_cmd(MODE_PUSH_BACK, VAL_MAX, 1'b0);
		queue_cmd(MODE_FIND, -1, 1'b0);
		queue_cmd(MODE_FIND, 1, 1'b0);
		// delete takes the first match from the front; a miss changes nothing
		queue_cmd(MODE_DELETE, VAL_MAX, 1'b0);
		queue_cmd(MODE_DELETE, 12345, 1'b0);
		queue_cmd(MODE_POP_BACK, 0, 1'b0);
		// popping a stored -1 reports ok
		queue_cmd(MODE_POP_BACK, 0, 1'b0);
		queue_cmd(MODE_POP_FRONT, 0, 1'b0);
		queue_cmd(MODE_FIND, VAL_MAX, 1'b0);
		queue_cmd(MODE_POP_BACK, 0, 1'b0);
		queue_random_cmds();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wait until every item is in and answered, then let the block settle
		while (pending_cmds.size() != 0 || awaited_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d items: push f/b %0d/%0d, pop f/b %0d/%0d, delete %0d, find %0d, spare %0d",
			n_accepted, mode_hits[MODE_PUSH_FRONT], mode_hits[MODE_PUSH_BACK],
			mode_hits[MODE_POP_FRONT], mode_hits[MODE_POP_BACK], mode_hits[MODE_DELETE],
			mode_hits[MODE_FIND], mode_hits[MODE_SPARE6] + mode_hits[MODE_SPARE7]);
		$display("Pushes dropped on full: %0d, pops on empty: %0d, search matches: %0d",
			full_hits, empty_hits, match_hits);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
